/* rtl/mlps_pkg.sv */
package mlps_pkg;

   // Operation codes carried in the request.
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_RESCHED = 2'd1;
   localparam logic [1:0] OP_EXIT    = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NO_RUN = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   localparam int REQ_W = 16;
   localparam int RSP_W = 16;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START_CHK,
      ST_DISPATCH,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_POP,
      ST_POP_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] op;
      logic [5:0] thread_id;
      logic [2:0] priority_req;
   } req_type;

   // First field in the highest bits, so the struct maps straight onto tdata.
   typedef struct packed {
      logic [1:0] result_status;
      logic       previous_valid;
      logic [5:0] previous_id;
      logic       new_running_valid;
      logic [5:0] new_running_id;
   } rsp_type;

endpackage

/* rtl/mlps_ram.sv */
module mlps_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 7
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/mlps_ctrl.sv */
module mlps_ctrl #(
   parameter int NUM_LEVELS  = 8,
   parameter int MAX_THREADS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  mlps_pkg::req_type req,
   output logic              req_ready,
   input  logic              out_free,
   output logic              res_valid,
   output mlps_pkg::rsp_type res
);

   localparam int SLOT_W = $clog2(MAX_THREADS);
   localparam int LINK_W = $clog2(MAX_THREADS + 1);
   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_THREADS);

   mlps_pkg::state_type state_ff, state_in;

   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [1:0]        op_ff, op_in;
   logic [5:0]        tid_ff, tid_in;
   logic [2:0]        prio_ff, prio_in;
   logic [5:0]        prev_id_ff, prev_id_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [1:0]        status_ff, status_in;
   logic [SLOT_W-1:0] push_slot_ff, push_slot_in;
   logic [LVL_W-1:0]  push_lvl_ff, push_lvl_in;
   logic [SLOT_W-1:0] old_head_ff, old_head_in;
   logic [LVL_W-1:0]  pop_lvl_ff, pop_lvl_in;
   logic [SLOT_W-1:0] pop_slot_ff, pop_slot_in;
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [SLOT_W-1:0] run_slot_ff, run_slot_in;
   logic              run_present_ff, run_present_in;
   logic [LVL_W-1:0]  run_level_ff, run_level_in;

   logic [SLOT_W-1:0] head_ff [NUM_LEVELS];
   logic [SLOT_W-1:0] tail_ff [NUM_LEVELS];
   logic              head_we, tail_we;
   logic [LVL_W-1:0]  head_wlvl, tail_wlvl;
   logic [SLOT_W-1:0] head_wdata, tail_wdata;

   logic              busy_we, busy_wdata, busy_rdata;
   logic [SLOT_W-1:0] busy_waddr, busy_raddr;
   logic              link_we;
   logic [SLOT_W-1:0] link_waddr, link_raddr;
   logic [LINK_W-1:0] link_wdata, link_rdata;

   logic [SLOT_W+5:0] req_tid_ext, tid_ext;
   logic [SLOT_W+5:0] run_ext;
   logic [SLOT_W:0]   push_link_ext;
   logic [LVL_W+2:0]  prio_ext;
   logic [SLOT_W-1:0] tid_slot;
   logic [LVL_W-1:0]  prio_sat;
   logic              tid_ok;
   logic [5:0]        run_id6;
   logic              ff_found;
   logic [LVL_W-1:0]  ff_lvl;

   // Width adaptation between the fixed field widths and the storage widths.
   assign req_tid_ext   = {{SLOT_W{1'b0}}, req.thread_id};
   assign tid_ext       = {{SLOT_W{1'b0}}, tid_ff};
   assign tid_slot      = tid_ext[SLOT_W-1:0];
   assign tid_ok        = (32'(tid_ff) < MAX_THREADS);
   assign prio_ext      = {{LVL_W{1'b0}}, prio_ff};
   assign prio_sat      = (32'(prio_ff) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                       : prio_ext[LVL_W-1:0];
   assign run_ext       = {6'b0, run_slot_ff};
   assign run_id6       = run_ext[5:0];
   assign push_link_ext = {1'b0, push_slot_ff};

   // Most urgent non-empty level.
   always_comb begin
      ff_found = |nonempty_ff;
      ff_lvl   = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            ff_lvl = LVL_W'(i);
         end
      end
   end

   mlps_ram #(.DEPTH(MAX_THREADS), .WIDTH(1)) u_busy (
      .clock (clock),
      .we    (busy_we),
      .waddr (busy_waddr),
      .wdata (busy_wdata),
      .raddr (busy_raddr),
      .rdata (busy_rdata)
   );

   mlps_ram #(.DEPTH(MAX_THREADS), .WIDTH(LINK_W)) u_link (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlps_pkg::ST_CLEAR: begin
            if (clr_ff == SLOT_W'(MAX_THREADS - 1)) state_in = mlps_pkg::ST_IDLE;
         end
         mlps_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req.op == mlps_pkg::OP_START) ? mlps_pkg::ST_START_CHK
                                                         : mlps_pkg::ST_DISPATCH;
            end
         end
         mlps_pkg::ST_START_CHK: begin
            state_in = (!tid_ok || busy_rdata) ? mlps_pkg::ST_DONE : mlps_pkg::ST_PUSH_A;
         end
         mlps_pkg::ST_DISPATCH: begin
            unique case (op_ff)
               mlps_pkg::OP_RESCHED: state_in = run_present_ff ? mlps_pkg::ST_PUSH_A
                                                              : mlps_pkg::ST_POP;
               mlps_pkg::OP_EXIT:    state_in = mlps_pkg::ST_POP;
               default:              state_in = mlps_pkg::ST_DONE;
            endcase
         end
         mlps_pkg::ST_PUSH_A: begin
            if (nonempty_ff[push_lvl_ff]) begin
               state_in = mlps_pkg::ST_PUSH_B;
            end else begin
               state_in = (op_ff == mlps_pkg::OP_START) ? mlps_pkg::ST_DONE : mlps_pkg::ST_POP;
            end
         end
         mlps_pkg::ST_PUSH_B: begin
            state_in = (op_ff == mlps_pkg::OP_START) ? mlps_pkg::ST_DONE : mlps_pkg::ST_POP;
         end
         mlps_pkg::ST_POP: begin
            state_in = ff_found ? mlps_pkg::ST_POP_WAIT : mlps_pkg::ST_DONE;
         end
         mlps_pkg::ST_POP_WAIT: begin
            state_in = mlps_pkg::ST_DONE;
         end
         mlps_pkg::ST_DONE: begin
            if (out_free) state_in = mlps_pkg::ST_IDLE;
         end
         default: state_in = mlps_pkg::ST_CLEAR;
      endcase
   end

   // Datapath and memory controls for each step.
   always_comb begin
      clr_in         = clr_ff;
      op_in          = op_ff;
      tid_in         = tid_ff;
      prio_in        = prio_ff;
      prev_id_in     = prev_id_ff;
      prev_valid_in  = prev_valid_ff;
      status_in      = status_ff;
      push_slot_in   = push_slot_ff;
      push_lvl_in    = push_lvl_ff;
      old_head_in    = old_head_ff;
      pop_lvl_in     = pop_lvl_ff;
      pop_slot_in    = pop_slot_ff;
      nonempty_in    = nonempty_ff;
      run_slot_in    = run_slot_ff;
      run_present_in = run_present_ff;
      run_level_in   = run_level_ff;
      head_we        = 1'b0;
      head_wlvl      = push_lvl_ff;
      head_wdata     = push_slot_ff;
      tail_we        = 1'b0;
      tail_wlvl      = push_lvl_ff;
      tail_wdata     = push_slot_ff;
      busy_we        = 1'b0;
      busy_waddr     = tid_slot;
      busy_wdata     = 1'b0;
      busy_raddr     = req_tid_ext[SLOT_W-1:0];
      link_we        = 1'b0;
      link_waddr     = push_slot_ff;
      link_wdata     = LINK_NONE;
      link_raddr     = tail_ff[ff_lvl];
      req_ready      = 1'b0;
      res_valid      = 1'b0;

      unique case (state_ff)
         mlps_pkg::ST_CLEAR: begin
            busy_we    = 1'b1;
            busy_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
         end
         mlps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               op_in         = req.op;
               tid_in        = req.thread_id;
               prio_in       = req.priority_req;
               prev_id_in    = run_present_ff ? run_id6 : 6'd0;
               prev_valid_in = run_present_ff;
               status_in     = mlps_pkg::STATUS_OK;
            end
         end
         mlps_pkg::ST_START_CHK: begin
            if (!tid_ok || busy_rdata) begin
               status_in = mlps_pkg::STATUS_REJECT;
            end else begin
               busy_we      = 1'b1;
               busy_waddr   = tid_slot;
               busy_wdata   = 1'b1;
               push_slot_in = tid_slot;
               push_lvl_in  = prio_sat;
            end
         end
         mlps_pkg::ST_DISPATCH: begin
            if (run_present_ff && op_ff == mlps_pkg::OP_RESCHED) begin
               push_slot_in = run_slot_ff;
               push_lvl_in  = run_level_ff;
            end
            if (run_present_ff && op_ff == mlps_pkg::OP_EXIT) begin
               busy_we    = 1'b1;
               busy_waddr = run_slot_ff;
               busy_wdata = 1'b0;
            end
         end
         mlps_pkg::ST_PUSH_A: begin
            // The new slot becomes the newest entry of its level.
            link_we    = 1'b1;
            link_waddr = push_slot_ff;
            link_wdata = LINK_NONE;
            head_we    = 1'b1;
            if (nonempty_ff[push_lvl_ff]) begin
               old_head_in = head_ff[push_lvl_ff];
            end else begin
               tail_we = 1'b1;
            end
            nonempty_in[push_lvl_ff] = 1'b1;
         end
         mlps_pkg::ST_PUSH_B: begin
            link_we    = 1'b1;
            link_waddr = old_head_ff;
            link_wdata = push_link_ext[LINK_W-1:0];
         end
         mlps_pkg::ST_POP: begin
            run_present_in = 1'b0;
            run_slot_in    = '0;
            run_level_in   = '0;
            if (ff_found) begin
               pop_lvl_in  = ff_lvl;
               pop_slot_in = tail_ff[ff_lvl];
            end else begin
               status_in = mlps_pkg::STATUS_NO_RUN;
            end
         end
         mlps_pkg::ST_POP_WAIT: begin
            if (link_rdata != LINK_NONE) begin
               tail_we    = 1'b1;
               tail_wlvl  = pop_lvl_ff;
               tail_wdata = link_rdata[SLOT_W-1:0];
            end else begin
               nonempty_in[pop_lvl_ff] = 1'b0;
            end
            run_slot_in    = pop_slot_ff;
            run_level_in   = pop_lvl_ff;
            run_present_in = 1'b1;
            busy_we        = 1'b1;
            busy_waddr     = pop_slot_ff;
            busy_wdata     = 1'b1;
         end
         mlps_pkg::ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   assign res.new_running_id    = run_present_ff ? run_id6 : 6'd0;
   assign res.new_running_valid = run_present_ff;
   assign res.previous_id       = prev_id_ff;
   assign res.previous_valid    = prev_valid_ff;
   assign res.result_status     = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mlps_pkg::ST_CLEAR;
         clr_ff         <= '0;
         nonempty_ff    <= '0;
         run_slot_ff    <= '0;
         run_present_ff <= 1'b0;
         run_level_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         nonempty_ff    <= nonempty_in;
         run_slot_ff    <= run_slot_in;
         run_present_ff <= run_present_in;
         run_level_ff   <= run_level_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tid_ff        <= tid_in;
      prio_ff       <= prio_in;
      prev_id_ff    <= prev_id_in;
      prev_valid_ff <= prev_valid_in;
      status_ff     <= status_in;
      push_slot_ff  <= push_slot_in;
      push_lvl_ff   <= push_lvl_in;
      old_head_ff   <= old_head_in;
      pop_lvl_ff    <= pop_lvl_in;
      pop_slot_ff   <= pop_slot_in;
      if (head_we) begin
         head_ff[head_wlvl] <= head_wdata;
      end
      if (tail_we) begin
         tail_ff[tail_wlvl] <= tail_wdata;
      end
   end

endmodule

/* rtl/multilevel_priority_scheduler.sv */
// Strict-priority multilevel FIFO thread scheduler.
// Requests arrive on the req_ stream: a start makes a thread slot runnable at
// a priority level (level 0 is the most urgent), a reschedule puts the running
// thread back at the end of its level and picks the next one, and an exit
// drops the running thread before picking. Every request gives exactly one
// transfer on the rsp_ stream, carrying the previous and new running thread
// and a status.
// A request is worked on in steps from its transfer to its result being
// registered at the output: a start does a busy-flag lookup and up to two
// writes into the link memory for the enqueue; a reschedule does up to two
// such writes to put back the running thread, and a reschedule or an exit
// then does at most one link-memory read for the dequeue. The link and busy
// memories take one read and one write a cycle. The sequencer takes one
// request at a time and is ready again once the result has been registered.
// After reset the busy-flag memory is swept clear, one slot a cycle;
// req_tready stays low until the sweep has ended.
// The result sits in an output register. While the receiver stalls, the next
// request is still taken and worked on, and its result waits inside the
// sequencer until the output register is free.
module multilevel_priority_scheduler #(
   parameter int NUM_LEVELS  = 8,
   parameter int MAX_THREADS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [1:0] op, [7:2] thread_id, [10:8] priority_req, [15:11] zero
   input  logic [mlps_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [5:0] new_running_id, [6] new_running_valid, [12:7] previous_id,
   // [13] previous_valid, [15:14] result_status
   output logic [mlps_pkg::RSP_W-1:0] rsp_tdata
);

   mlps_pkg::req_type req;
   mlps_pkg::rsp_type res;
   mlps_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ctrl_ready, res_valid, out_free, req_fire, take;

   assign req.op           = req_tdata[1:0];
   assign req.thread_id    = req_tdata[7:2];
   assign req.priority_req = req_tdata[10:8];

   assign req_tready = ctrl_ready;
   assign req_fire   = req_tvalid && ctrl_ready;

   // The output register is free when empty or when its content leaves now.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign take     = res_valid && out_free;

   mlps_ctrl #(
      .NUM_LEVELS  (NUM_LEVELS),
      .MAX_THREADS (MAX_THREADS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req       (req),
      .req_ready (ctrl_ready),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_data_in  = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/mlps_checker.sv */
module mlps_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [mlps_pkg::REQ_W-1:0] req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [mlps_pkg::RSP_W-1:0] rsp_tdata
);

   // A stalled result holds its place and its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No running thread means the id field reads zero.
   a_new_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> rsp_tdata[5:0] == 6'd0)
      else $error("new running id set without a running thread");

   a_prev_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[13] |-> rsp_tdata[12:7] == 6'd0)
      else $error("previous id set without a previous thread");

   // An empty pick leaves nothing running.
   a_no_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:14] == mlps_pkg::STATUS_NO_RUN |-> !rsp_tdata[6])
      else $error("thread reported running after an empty pick");

   // A request that is offered but not yet taken stays offered and unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request withdrawn or changed before its transfer");

endmodule

bind multilevel_priority_scheduler mlps_checker u_mlps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
